// File: rtl/core/ttip_pkg.sv
`default_nettype none

package ttip_pkg;

  // character codes, compared on the low byte
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChLoO   = 8'h6F;
  localparam logic [7:0] ChLoB   = 8'h62;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] CaseGap = 8'h20;

  // number bases
  localparam int unsigned BaseW = 5;
  localparam logic [BaseW-1:0] BaseAuto = 5'd0;
  localparam logic [BaseW-1:0] BaseBin  = 5'd2;
  localparam logic [BaseW-1:0] BaseOct  = 5'd8;
  localparam logic [BaseW-1:0] BaseDec  = 5'd10;
  localparam logic [BaseW-1:0] BaseHex  = 5'd16;

  typedef enum logic [1:0] {
    PhStart,
    PhPrefix,
    PhDigits,
    PhDone
  } phase_e;

  // one input beat
  typedef struct packed {
    logic [15:0] char_code;
    logic        char_present;
    logic        last;
  } char_beat_t;

  // one result beat
  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } result_t;

  // classified character
  typedef struct packed {
    logic       is_null;
    logic       is_minus;
    logic       is_plus;
    logic       is_x;
    logic       is_o;
    logic       is_b;
    logic       has_digit;
    logic [3:0] digit;
  } char_class_t;

  // running parse state of one string
  typedef struct packed {
    phase_e           phase;
    logic             negative;
    logic [BaseW-1:0] base;
    logic [31:0]      acc;
    logic             invalid;
  } parse_state_t;

endpackage

`default_nettype wire

// File: rtl/core/ttip_char_decode.sv
`default_nettype none

module ttip_char_decode (
  input  logic [15:0]                char_code_i,
  output ttip_pkg::char_class_t      class_o
);
  import ttip_pkg::*;

  logic [7:0] low;
  logic [7:0] lc;

  // lowercase the low byte
  assign low = char_code_i[7:0];
  assign lc  = (low >= ChUpA && low <= ChUpZ) ? low + CaseGap : low;

  // sign, prefix and digit classes
  always_comb begin
    class_o          = '0;
    class_o.is_null  = (char_code_i == 16'h0000);
    class_o.is_minus = (low == ChMinus);
    class_o.is_plus  = (low == ChPlus);
    class_o.is_x     = (lc == ChLoX);
    class_o.is_o     = (lc == ChLoO);
    class_o.is_b     = (lc == ChLoB);
    if (lc >= ChZero && lc <= ChNine) begin
      class_o.has_digit = 1'b1;
      class_o.digit     = 4'(lc - ChZero);
    end else if (lc >= ChLoA && lc <= ChLoF) begin
      class_o.has_digit = 1'b1;
      class_o.digit     = 4'(lc - ChLoA + 8'd10);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ttip_parse_step.sv
`default_nettype none

module ttip_parse_step (
  input  ttip_pkg::parse_state_t     state_i,
  input  ttip_pkg::char_class_t      class_i,
  input  logic [ttip_pkg::BaseW-1:0] base_select_i,
  output ttip_pkg::parse_state_t     state_o
);
  import ttip_pkg::*;

  logic        used;
  logic        stop;
  logic [31:0] scaled;

  // one character through sign, prefix and digit handling
  always_comb begin
    state_o = state_i;
    used    = 1'b0;
    stop    = 1'b0;
    scaled  = '0;

    // sign at string start, base sampled here
    if (state_o.phase == PhStart) begin
      state_o.base = base_select_i;
      if (class_i.is_minus) begin
        state_o.negative = 1'b1;
        used             = 1'b1;
      end else if (class_i.is_plus) begin
        used = 1'b1;
      end
      if (base_select_i == BaseAuto) begin
        state_o.phase = PhPrefix;
      end else if (base_select_i == BaseBin || base_select_i == BaseOct ||
                   base_select_i == BaseDec || base_select_i == BaseHex) begin
        state_o.phase = PhDigits;
      end else begin
        state_o.invalid = 1'b1;
        state_o.phase   = PhDone;
      end
    end

    // prefix letter picks the base
    if (!used && state_o.phase == PhPrefix) begin
      if (class_i.is_null) begin
        state_o.invalid = 1'b1;
        state_o.phase   = PhDone;
        used            = 1'b1;
      end else begin
        if (class_i.is_x) begin
          state_o.base = BaseHex;
          used         = 1'b1;
        end else if (class_i.is_o) begin
          state_o.base = BaseOct;
          used         = 1'b1;
        end else if (class_i.is_b) begin
          state_o.base = BaseBin;
          used         = 1'b1;
        end else begin
          state_o.base = BaseDec;
        end
        state_o.phase = PhDigits;
      end
    end

    // digit accumulate, multiply by base as shift and add
    if (!used && state_o.phase == PhDigits) begin
      stop = class_i.is_null || !class_i.has_digit ||
             ({1'b0, class_i.digit} >= state_o.base);
      case (state_o.base)
        BaseBin: scaled = {state_o.acc[30:0], 1'b0};
        BaseOct: scaled = {state_o.acc[28:0], 3'b000};
        BaseHex: scaled = {state_o.acc[27:0], 4'b0000};
        default: scaled = {state_o.acc[28:0], 3'b000} + {state_o.acc[30:0], 1'b0};
      endcase
      if (stop) begin
        state_o.phase = PhDone;
      end else begin
        state_o.acc = scaled + {28'd0, class_i.digit};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/text_to_integer_parser.sv
`default_nettype none

// channel   dir  handshake               payload
// in        in   in_valid_i/in_stall_o   in_data_i   (char_code, char_present, last)
// out       out  out_valid_o/out_stall_i out_data_o  (value, status)
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i  (base_select)
//
// one character beat per cycle unless stalled; a beat is held in the input
// register, where decode, the parse step and the accumulator multiply-add
// are combinational, and a result is registered when its last beat fires.
// reset clears the parse state, base_select and both valid flags.
// a last beat waits in the input register only while the result register
// is full and stalled; other beats never wait.
module text_to_integer_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ttip_pkg::char_beat_t       in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ttip_pkg::result_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ttip_pkg::BaseW-1:0] cfg_data_i
);
  import ttip_pkg::*;

  logic                 in_valid_q, in_valid_d;
  char_beat_t           in_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;
  parse_state_t         state_q, state_d;
  logic [BaseW-1:0]     base_select_q;
  char_class_t          char_class;
  parse_state_t         stepped;
  parse_state_t         final_st;
  logic                 out_free;
  logic                 fire;
  logic                 accept;

  ttip_char_decode u_decode (
    .char_code_i (in_q.char_code),
    .class_o     (char_class)
  );

  ttip_parse_step u_step (
    .state_i       (state_q),
    .class_i       (char_class),
    .base_select_i (base_select_q),
    .state_o       (stepped)
  );

  // handshake control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && (!in_q.last || out_free);
  assign in_stall_o  = in_valid_q && !fire;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // state after this beat, and the result on a last beat
  always_comb begin
    final_st = in_q.char_present ? stepped : state_q;
    if (final_st.phase == PhPrefix) begin
      final_st.invalid = 1'b1;
    end
    out_d.status = final_st.invalid;
    if (final_st.invalid) begin
      out_d.value = '0;
    end else if (final_st.negative) begin
      out_d.value = 32'd0 - final_st.acc;
    end else begin
      out_d.value = final_st.acc;
    end

    state_d     = state_q;
    in_valid_d  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      if (in_q.last) begin
        state_d       = '0;
        state_d.phase = PhStart;
        out_valid_d   = 1'b1;
      end else begin
        state_d = in_q.char_present ? stepped : state_q;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= '0;
      base_select_q <= BaseAuto;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_select_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (fire && in_q.last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
